// File: hdl/assert_macros.svh
// assertion helpers, clocked on clk and disabled while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// expression holds at every clock edge
`define ASSERT_HOLDS(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_HOLDS(lbl, expr, msg)
`define ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// File: hdl/rdc_pkg.sv
package rdc_pkg;

    // field widths
    localparam int VALUE_WIDTH = 31;
    localparam int MAX_DIGITS  = 31;
    localparam int RADIX_W     = 5;
    localparam int DIGIT_W     = 4;
    localparam int CHAR_W      = 7;

    // divider: bits retired per cycle and derived step count
    localparam int BITS_PER_STEP = 8;
    localparam int DIV_STEPS     = (VALUE_WIDTH + BITS_PER_STEP - 1) / BITS_PER_STEP;
    localparam int PAD_W         = DIV_STEPS * BITS_PER_STEP;
    localparam int STEP_CNT_W    = $clog2(DIV_STEPS + 1);

    // digit store indexing
    localparam int IDX_W = $clog2(MAX_DIGITS);

    // input queue
    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // radix limits
    localparam logic [RADIX_W-1:0] RADIX_MIN = 5'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX = 5'd16;

    // character codes
    localparam logic [CHAR_W-1:0]  ASCII_ZERO        = 7'd48;
    localparam logic [CHAR_W-1:0]  ASCII_LETTER_BASE = 7'd55;
    localparam logic [DIGIT_W-1:0] DECIMAL_LIMIT     = 4'd10;

    // one conversion request
    typedef struct packed {
        logic [VALUE_WIDTH-1:0] value;
        logic [RADIX_W-1:0]     radix;
    } job_t;

    // queue head as seen by the back end
    typedef struct packed {
        logic valid;
        job_t job;
    } q_stat_t;

    // back end status toward the queue
    typedef struct packed {
        logic pop;
        logic busy;
    } bk_stat_t;

    // divider start request
    typedef struct packed {
        logic                   start;
        logic [VALUE_WIDTH-1:0] dividend;
        logic [RADIX_W-1:0]     radix;
    } div_req_t;

    // divider result, valid while done is high
    typedef struct packed {
        logic                   done;
        logic [VALUE_WIDTH-1:0] quot;
        logic [DIGIT_W-1:0]     rem;
    } div_rsp_t;

    // back end sequencer states
    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_EMIT = 3'b100
    } bk_state_t;

    // digit value to ascii character
    function automatic logic [CHAR_W-1:0] ascii_of(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] dx;
        dx = {{(CHAR_W - DIGIT_W){1'b0}}, d};
        if (d < DECIMAL_LIMIT)
            return ASCII_ZERO + dx;
        return ASCII_LETTER_BASE + dx;
    endfunction

    // force radix into the supported range
    function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
        if (r < RADIX_MIN)
            return RADIX_MIN;
        if (r > RADIX_MAX)
            return RADIX_MAX;
        return r;
    endfunction

endpackage

// File: hdl/rdc_queue.sv
module rdc_queue (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [rdc_pkg::VALUE_WIDTH-1:0] value,
    input  logic [rdc_pkg::RADIX_W-1:0]     radix,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          pop,
    output rdc_pkg::q_stat_t              q
);
    import rdc_pkg::*;

    job_t              mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    logic              push;
    job_t              job_in;

    // accept while there is room
    assign in_stall = (cnt_reg == QCNT_W'(QDEPTH));
    assign push     = in_valid && !in_stall;

    // classify: radix clamped on entry
    always_comb
    begin
        job_in.value = value;
        job_in.radix = clamp_radix(radix);
    end

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= job_in;
    end

    // queue head
    assign q.valid = (cnt_reg != '0);
    assign q.job   = mem_reg[rd_ptr_reg];

endmodule

// File: hdl/rdc_divider.sv
module rdc_divider (
    input  logic              clk,
    input  logic              rst_n,
    input  rdc_pkg::div_req_t req,
    output rdc_pkg::div_rsp_t rsp
);
    import rdc_pkg::*;

    logic [PAD_W-1:0]      sh_reg, sh_next;
    logic [DIGIT_W-1:0]    rem_reg, rem_next;
    logic [RADIX_W-1:0]    radix_reg, radix_next;
    logic [STEP_CNT_W-1:0] cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic [PAD_W-1:0]      sh_step;
    logic [DIGIT_W-1:0]    rem_step;
    logic [DIGIT_W:0]      part;

    // restoring division, a few bits per cycle; quotient shifts in at the bottom
    always_comb
    begin
        sh_step  = sh_reg;
        rem_step = rem_reg;
        part     = '0;
        for (int i = 0; i < BITS_PER_STEP; i++)
        begin
            part    = {rem_step, sh_step[PAD_W-1]};
            sh_step = {sh_step[PAD_W-2:0], 1'b0};
            if (part >= (DIGIT_W+1)'(radix_reg))
            begin
                part       = part - (DIGIT_W+1)'(radix_reg);
                sh_step[0] = 1'b1;
            end
            rem_step = part[DIGIT_W-1:0];
        end
    end

    // iteration control
    always_comb
    begin
        sh_next    = sh_reg;
        rem_next   = rem_reg;
        radix_next = radix_reg;
        cnt_next   = cnt_reg;
        busy_next  = busy_reg;
        if (req.start)
        begin
            sh_next    = PAD_W'(req.dividend);
            rem_next   = '0;
            radix_next = req.radix;
            cnt_next   = STEP_CNT_W'(DIV_STEPS);
            busy_next  = 1'b1;
        end
        else if (busy_reg)
        begin
            sh_next   = sh_step;
            rem_next  = rem_step;
            cnt_next  = cnt_reg - 1'b1;
            busy_next = (cnt_reg != STEP_CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sh_reg    <= sh_next;
        rem_reg   <= rem_next;
        radix_reg <= radix_next;
    end

    // result on the final step
    assign rsp.done = busy_reg && (cnt_reg == STEP_CNT_W'(1));
    assign rsp.quot = sh_step[VALUE_WIDTH-1:0];
    assign rsp.rem  = rem_step;

endmodule

// File: hdl/rdc_back.sv
module rdc_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  rdc_pkg::q_stat_t            q,
    output rdc_pkg::bk_stat_t           stat,
    output logic [rdc_pkg::CHAR_W-1:0]  digit_char,
    output logic                        last_digit,
    output logic                        out_valid,
    input  logic                        out_stall
);
    import rdc_pkg::*;

    bk_state_t          state_reg, state_next;
    logic [IDX_W-1:0]   n_reg, n_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [RADIX_W-1:0] radix_reg, radix_next;
    logic               out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0]  char_reg, char_next;
    logic               last_reg, last_next;
    logic [DIGIT_W-1:0] store_reg [MAX_DIGITS];
    logic               wr_en;
    logic               pop;
    div_req_t           req;
    div_rsp_t           rsp;

    rdc_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    // sequencer: take a job, divide digit by digit, then send digits out
    always_comb
    begin
        state_next     = state_reg;
        n_next         = n_reg;
        idx_next       = idx_reg;
        radix_next     = radix_reg;
        out_valid_next = out_valid_reg && out_stall;
        char_next      = char_reg;
        last_next      = last_reg;
        wr_en          = 1'b0;
        pop            = 1'b0;
        req.start      = 1'b0;
        req.dividend   = rsp.quot;
        req.radix      = radix_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q.valid)
                begin
                    pop          = 1'b1;
                    req.start    = 1'b1;
                    req.dividend = q.job.value;
                    req.radix    = q.job.radix;
                    radix_next   = q.job.radix;
                    n_next       = '0;
                    state_next   = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (rsp.done)
                begin
                    wr_en = 1'b1;
                    if (rsp.quot == '0 || n_reg == IDX_W'(MAX_DIGITS - 1))
                    begin
                        idx_next   = n_reg;
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        req.start = 1'b1;
                        n_next    = n_reg + 1'b1;
                    end
                end
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    char_next      = ascii_of(store_reg[idx_reg]);
                    last_next      = (idx_reg == '0);
                    if (idx_reg == '0)
                        state_next = ST_IDLE;
                    else
                        idx_next = idx_reg - 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            n_reg         <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            n_reg         <= n_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers and digit store
    always_ff @(posedge clk)
    begin
        radix_reg <= radix_next;
        char_reg  <= char_next;
        last_reg  <= last_next;
        if (wr_en)
            store_reg[n_reg] <= rsp.rem;
    end

    assign stat.pop   = pop;
    assign stat.busy  = (state_reg != ST_IDLE);
    assign digit_char = char_reg;
    assign last_digit = last_reg;
    assign out_valid  = out_valid_reg;

endmodule

// File: hdl/radix_digit_converter.sv
// radix_digit_converter: integer to radix string
//
// input channel: value (31 bits) and radix, transfer when in_valid is high
// and in_stall is low. radix below 2 counts as 2, above 16 as 16.
// output channel: one transfer per digit, digit_char is the ascii character
// '0'-'9' or 'A'-'F', most significant first; last_digit marks the final one.
// a value of zero gives the single character '0'.
// a two-entry queue takes items while the back end works, so in_stall rises
// only when both entries are taken.
// for an item of d digits the back end takes it from the queue, divides
// once per digit (the divider retires 8 quotient bits per cycle), then sends
// the characters, one per cycle when out_stall stays low. the back end works
// on one item at a time, from taking it to sending its last character (d up
// to 31 in radix 2). while out_stall is high the output register holds its
// character and the back end holds off its next character. reset clears the
// queue, sequencer and output valid; no clearing pass is needed, the block
// takes items right after reset.
`include "assert_macros.svh"

module radix_digit_converter (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [rdc_pkg::VALUE_WIDTH-1:0] value,
    input  logic [rdc_pkg::RADIX_W-1:0]     radix,
    input  logic                            in_valid,
    output logic                            in_stall,
    output logic [rdc_pkg::CHAR_W-1:0]      digit_char,
    output logic                            last_digit,
    output logic                            out_valid,
    input  logic                            out_stall
);
    import rdc_pkg::*;

    q_stat_t  q;
    bk_stat_t stat;

    // front: accept, clamp and queue
    rdc_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .value    (value),
        .radix    (radix),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .pop      (stat.pop),
        .q        (q)
    );

    // back: digit division and character output
    rdc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q          (q),
        .stat       (stat),
        .digit_char (digit_char),
        .last_digit (last_digit),
        .out_valid  (out_valid),
        .out_stall  (out_stall)
    );

    // checks
    `ASSERT_HOLDS(a_pop_nonempty, !stat.pop || q.valid, "back end popped an empty queue")
    `ASSERT_NEXT(a_push_queued, in_valid && !in_stall, q.valid, "accepted item not queued")
    `ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "stalled output dropped")

endmodule
